### rtl/ppa_pkg.sv
// shared types, constants and helpers for the planar polygon area unit
// no dependencies
package ppa_pkg;

  // fixed field widths
  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int NORM_W  = 34;
  localparam int SUM_W   = 2 * COORD_W + 12;
  localparam int DOT_W   = 80;
  localparam int NN_W    = 68;
  localparam int ROOT_W  = NN_W / 2;
  localparam int SREM_W  = ROOT_W + 4;
  localparam int DREM_W  = ROOT_W;
  localparam int AREA_W  = 36;
  localparam int STAT_W  = 2;

  localparam int MAX_VERTICES = 1024;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  // sequencer step counts
  localparam int MAC_STEPS  = 6;
  localparam int MUL_STEPS  = NORM_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = DOT_W;
  localparam int SEQ_W      = 7;
  localparam int STEP_W     = 3;
  localparam int K_W        = 2;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FEW   = 2'd1,
    STAT_DEGEN = 2'd2
  } area_stat_e;

  typedef enum logic [1:0] {
    MM_ACC,
    MM_NRM,
    MM_CLOSE
  } mac_mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROUTE,
    S_ACC,
    S_NRM,
    S_COMMIT,
    S_CHECK,
    S_CLOSE,
    S_MLOAD,
    S_MULT,
    S_SQINIT,
    S_SQRT,
    S_DVINIT,
    S_DIV,
    S_DONE
  } ppa_state_e;

  typedef struct packed {
    logic              load;
    logic              mac_en;
    mac_mode_e         mac_mode;
    logic [STEP_W-1:0] step;
    logic              commit;
    logic              mul_load;
    logic              mul_step;
    logic [K_W-1:0]    kidx;
    logic              sq_init;
    logic              sq_step;
    logic              dv_init;
    logic              dv_step;
    logic              out_load;
    logic              clear;
  } ppa_cmd_t;

  typedef struct packed {
    logic last;
    logic cnt_zero;
    logic cnt_two;
    logic cnt_full;
    logic few;
    logic nzero;
    logic out_free;
  } ppa_stat_t;

  // cyclic successor indexes of a vector component
  function automatic logic [K_W-1:0] idx_p1(input logic [K_W-1:0] k);
    logic [K_W-1:0] r;
    case (k)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [K_W-1:0] idx_p2(input logic [K_W-1:0] k);
    logic [K_W-1:0] r;
    case (k)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

### rtl/ppa_ctrl.sv
// sequencer for the planar polygon area unit
// depends on ppa_pkg
module ppa_ctrl import ppa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ppa_stat_t stat_i,
  output ppa_cmd_t  cmd_o
);

  ppa_state_e       state_q, state_d;
  logic [SEQ_W-1:0] cnt_q, cnt_d;
  logic [K_W-1:0]   k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    k_d          = k_q;
    cmd_o        = '0;
    cmd_o.mac_mode = MM_ACC;
    cmd_o.step   = cnt_q[STEP_W-1:0];
    cmd_o.kidx   = k_q;
    in_stall_o   = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_ROUTE;
        end
      end
      S_ROUTE: begin
        cnt_d = '0;
        if (stat_i.cnt_full) begin
          state_d = stat_i.last ? S_CHECK : S_IDLE;
        end else if (stat_i.cnt_zero) begin
          state_d = S_COMMIT;
        end else begin
          state_d = S_ACC;
        end
      end
      S_ACC, S_NRM, S_CLOSE: begin
        cmd_o.mac_en   = (cnt_q < SEQ_W'(MAC_STEPS));
        cmd_o.mac_mode = (state_q == S_ACC) ? MM_ACC :
                         (state_q == S_NRM) ? MM_NRM : MM_CLOSE;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SEQ_W'(MAC_STEPS)) begin
          cnt_d = '0;
          k_d   = '0;
          case (state_q)
            S_ACC:   state_d = stat_i.cnt_two ? S_NRM : S_COMMIT;
            S_NRM:   state_d = S_COMMIT;
            default: state_d = S_MLOAD;
          endcase
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = stat_i.last ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        cnt_d   = '0;
        state_d = (stat_i.few || stat_i.nzero) ? S_DONE : S_CLOSE;
      end
      S_MLOAD: begin
        cmd_o.mul_load = 1'b1;
        cnt_d          = '0;
        state_d        = S_MULT;
      end
      S_MULT: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == SEQ_W'(MUL_STEPS - 1)) begin
          if (k_q == K_W'(2)) begin
            state_d = S_SQINIT;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_MLOAD;
          end
        end
      end
      S_SQINIT: begin
        cmd_o.sq_init = 1'b1;
        cnt_d         = '0;
        state_d       = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sq_step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == SEQ_W'(SQRT_STEPS - 1)) state_d = S_DVINIT;
      end
      S_DVINIT: begin
        cmd_o.dv_init = 1'b1;
        cnt_d         = '0;
        state_d       = S_DIV;
      end
      S_DIV: begin
        cmd_o.dv_step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == SEQ_W'(DIV_STEPS - 1)) state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clear    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### rtl/ppa_datapath.sv
// vertex store, cross product accumulator, dot product, isqrt and divider
// depends on ppa_pkg
module ppa_datapath import ppa_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  input  logic                      last_vertex_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic [AREA_W-1:0]         area_o,
  output logic [STAT_W-1:0]         status_o,
  input  ppa_cmd_t                  cmd_i,
  output ppa_stat_t                 stat_o
);

  logic signed [COORD_W-1:0] cur_q [3];
  logic signed [COORD_W-1:0] first_q [3];
  logic signed [COORD_W-1:0] second_q [3];
  logic signed [COORD_W-1:0] prev_q [3];
  logic                      last_q;
  logic [CNT_W-1:0]          vcnt_q;

  logic signed [NORM_W-1:0]  normal_q [3];
  logic [SUM_W-1:0]          sum_q [3];

  // multiplier pipeline stage
  logic signed [DIFF_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic [K_W-1:0]            pk_q;
  logic                      psub_q, pnrm_q, pvalid_q;
  logic [K_W-1:0]            mk, ia, ib;

  // dot product and norm
  logic [NORM_W-1:0]         mplier_q;
  logic [DOT_W-1:0]          mc_dot_q, dot_q;
  logic [NN_W-1:0]           mc_nn_q, nn_q;
  logic                      mneg_q;
  logic signed [NORM_W-1:0]  nsel;
  logic [SUM_W-1:0]          ssel;

  // isqrt and divider
  logic [NN_W-1:0]           rad_q;
  logic [ROOT_W-1:0]         root_q;
  logic [SREM_W-1:0]         srem_q, srem2, strial;
  logic [DOT_W-1:0]          num_q, q_q, dot_abs;
  logic [DREM_W-1:0]         drem_q;
  logic [DREM_W:0]           drem2;

  logic                      out_valid_q;
  logic [AREA_W-1:0]         area_q;
  area_stat_e                status_q;

  assign stat_o.last     = last_q;
  assign stat_o.cnt_zero = (vcnt_q == '0);
  assign stat_o.cnt_two  = (vcnt_q == CNT_W'(2));
  assign stat_o.cnt_full = (vcnt_q == CNT_W'(MAX_VERTICES));
  assign stat_o.few      = (vcnt_q < CNT_W'(3));
  assign stat_o.nzero    = (normal_q[0] == '0) && (normal_q[1] == '0) &&
                           (normal_q[2] == '0);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign area_o      = area_q;
  assign status_o    = status_q;

  // operand select for one cross product term
  always_comb begin
    mk = cmd_i.step[STEP_W-1:1];
    ia = cmd_i.step[0] ? idx_p2(mk) : idx_p1(mk);
    ib = cmd_i.step[0] ? idx_p1(mk) : idx_p2(mk);
    case (cmd_i.mac_mode)
      MM_NRM: begin
        op_a = DIFF_W'(second_q[ia]) - DIFF_W'(first_q[ia]);
        op_b = DIFF_W'(cur_q[ib]) - DIFF_W'(first_q[ib]);
      end
      MM_CLOSE: begin
        op_a = DIFF_W'(prev_q[ia]);
        op_b = DIFF_W'(first_q[ib]);
      end
      default: begin
        op_a = DIFF_W'(prev_q[ia]);
        op_b = DIFF_W'(cur_q[ib]);
      end
    endcase
    prod_d = op_a * op_b;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    pk_q   <= mk;
    psub_q <= cmd_i.step[0];
    pnrm_q <= (cmd_i.mac_mode == MM_NRM);
  end

  // vertex registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q[0] <= coord_x_i;
      cur_q[1] <= coord_y_i;
      cur_q[2] <= coord_z_i;
      last_q   <= last_vertex_i;
    end
    if (cmd_i.commit) begin
      prev_q <= cur_q;
      if (vcnt_q == '0) first_q <= cur_q;
      if (vcnt_q == CNT_W'(1)) second_q <= cur_q;
    end
  end

  // polygon accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
      vcnt_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        normal_q[i] <= '0;
        sum_q[i]    <= '0;
      end
      dot_q <= '0;
      nn_q  <= '0;
    end else begin
      pvalid_q <= cmd_i.mac_en;
      if (pvalid_q) begin
        if (pnrm_q) begin
          normal_q[pk_q] <= psub_q ? normal_q[pk_q] - NORM_W'(prod_q) : NORM_W'(prod_q);
        end else begin
          sum_q[pk_q] <= psub_q ? sum_q[pk_q] - SUM_W'(prod_q) : sum_q[pk_q] + SUM_W'(prod_q);
        end
      end
      if (cmd_i.commit) vcnt_q <= vcnt_q + 1'b1;
      if (cmd_i.mul_step && mplier_q[0]) begin
        dot_q <= mneg_q ? dot_q - mc_dot_q : dot_q + mc_dot_q;
        nn_q  <= nn_q + mc_nn_q;
      end
      if (cmd_i.clear) begin
        vcnt_q <= '0;
        dot_q  <= '0;
        nn_q   <= '0;
        for (int i = 0; i < 3; i++) begin
          normal_q[i] <= '0;
          sum_q[i]    <= '0;
        end
      end
    end
  end

  // shift-add multiply of one component
  assign nsel = normal_q[cmd_i.kidx];
  assign ssel = sum_q[cmd_i.kidx];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      mplier_q <= nsel[NORM_W-1] ? NORM_W'(-nsel) : NORM_W'(nsel);
      mc_nn_q  <= NN_W'(nsel[NORM_W-1] ? NORM_W'(-nsel) : NORM_W'(nsel));
      mc_dot_q <= DOT_W'(ssel[SUM_W-1] ? SUM_W'(-ssel) : ssel);
      mneg_q   <= nsel[NORM_W-1] ^ ssel[SUM_W-1];
    end else if (cmd_i.mul_step) begin
      mplier_q <= mplier_q >> 1;
      mc_dot_q <= mc_dot_q << 1;
      mc_nn_q  <= mc_nn_q << 1;
    end
  end

  // isqrt, two radicand bits a step
  assign srem2  = {srem_q[SREM_W-3:0], rad_q[NN_W-1 -: 2]};
  assign strial = {2'b00, root_q, 2'b01};
  // restoring divide, one quotient bit a step
  assign drem2   = {drem_q, num_q[DOT_W-1]};
  assign dot_abs = dot_q[DOT_W-1] ? DOT_W'(-dot_q) : dot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_init) begin
      rad_q  <= nn_q;
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.sq_step) begin
      rad_q <= rad_q << 2;
      if (srem2 >= strial) begin
        srem_q <= srem2 - strial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        srem_q <= srem2;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd_i.dv_init) begin
      num_q  <= dot_abs << 1;
      drem_q <= '0;
      q_q    <= '0;
    end else if (cmd_i.dv_step) begin
      num_q <= num_q << 1;
      if (drem2 >= {1'b0, root_q}) begin
        drem_q <= DREM_W'(drem2 - {1'b0, root_q});
        q_q    <= {q_q[DOT_W-2:0], 1'b1};
      end else begin
        drem_q <= drem2[DREM_W-1:0];
        q_q    <= {q_q[DOT_W-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (stat_o.few) begin
        status_q <= STAT_FEW;
        area_q   <= '0;
      end else if (stat_o.nzero) begin
        status_q <= STAT_DEGEN;
        area_q   <= '0;
      end else begin
        status_q <= STAT_OK;
        area_q   <= (|q_q[DOT_W-1:AREA_W]) ? '1 : q_q[AREA_W-1:0];
      end
    end
  end

endmodule

### rtl/planar_polygon_area_3d_unit.sv
// top level of the planar polygon area unit
// depends on ppa_pkg, ppa_ctrl, ppa_datapath
//
// channel  direction  handshake              payload
// vertex   in         in_valid_i/in_stall_o  coord_x_i coord_y_i coord_z_i last_vertex_i
// area     out        out_valid_o/out_stall_i area_o status_o
//
// a vertex other than the first runs six terms through one 17x17 multiplier,
// the third vertex two passes of six terms
// a closing vertex adds the closing term, the shift-add dot product,
// the isqrt and the restoring divider
// an ending vertex that fails the vertex count or normal check skips the area arithmetic
// reset is asynchronous and clears the polygon accumulators and the result valid flag
// a held result stalls the unit only when the next result is ready
module planar_polygon_area_3d_unit import ppa_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  input  logic                      last_vertex_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [AREA_W-1:0]         area_o,
  output logic [STAT_W-1:0]         status_o
);

  // command and status between sequencer and datapath
  ppa_cmd_t  cmd;
  ppa_stat_t stat;

  // sequencer: one request at a time, through accumulate, check and
  // the iterative area stages
  ppa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: vertex store, cross sums, normal, area arithmetic and
  // the output register
  ppa_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .last_vertex_i (last_vertex_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .area_o        (area_o),
    .status_o      (status_o),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

### rtl/ppa_checker.sv
// port level checks for the planar polygon area unit, bound to the top
// depends on ppa_pkg
module ppa_checker import ppa_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [AREA_W-1:0] area_o,
  input logic [STAT_W-1:0] status_o
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(area_o) && $stable(status_o))
    else $error("result changed while stalled");

  // no request taken in the cycle right after one
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken back to back");

  // status code is one of the three
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("bad status code");

  // error results carry zero area
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> area_o == '0)
    else $error("nonzero area on error");

endmodule

bind planar_polygon_area_3d_unit ppa_checker u_ppa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .area_o      (area_o),
  .status_o    (status_o)
);
